[hw/rtl/dtfe_pkg.sv]
// types, constants and coding tables for the dshot telemetry frame encoder
package dtfe_pkg;

  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CURRENT_DIV = 2'd0,
    CFG_VOLTAGE_DIV = 2'd1,
    CFG_TEMP_DIV    = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] CurrentDivReset = 8'd40;
  localparam logic [7:0] VoltageDivReset = 8'd200;
  localparam logic [7:0] TempDivReset    = 8'd200;

  // extended frame payloads and type prefixes
  localparam logic [11:0] ExtStartFrame = 12'hE00;
  localparam logic [11:0] ExtStopFrame  = 12'hEFF;
  localparam logic [3:0]  ExtCurrent    = 4'h6;
  localparam logic [3:0]  ExtVoltage    = 4'h4;
  localparam logic [3:0]  ExtTemp       = 4'h2;

  localparam logic [15:0] StoppedPeriod = 16'hFFFF;

  // reciprocal constants: x/100 = (x*5243)>>19 for x < 32768, x/25 = (x*83887)>>21 for 16 bits
  localparam logic [12:0] Recip100      = 13'd5243;
  localparam int          Recip100Shift = 19;
  localparam logic [16:0] Recip25       = 17'd83887;
  localparam int          Recip25Shift  = 21;
  localparam logic [14:0] AmpsSatLimit  = 15'd25600;

  function automatic logic [4:0] gcr_encode(input logic [3:0] nib);
    logic [4:0] code;
    case (nib)
      4'h0: code = 5'h19;
      4'h1: code = 5'h1B;
      4'h2: code = 5'h12;
      4'h3: code = 5'h13;
      4'h4: code = 5'h1D;
      4'h5: code = 5'h15;
      4'h6: code = 5'h16;
      4'h7: code = 5'h17;
      4'h8: code = 5'h1A;
      4'h9: code = 5'h09;
      4'hA: code = 5'h0A;
      4'hB: code = 5'h0B;
      4'hC: code = 5'h1E;
      4'hD: code = 5'h0D;
      4'hE: code = 5'h0E;
      default: code = 5'h0F;
    endcase
    return code;
  endfunction

endpackage

[hw/rtl/dshot_telemetry_frame_encoder.sv]
// dshot telemetry frame encoder: frame scheduling, checksum, gcr and line coding
// the result is registered: it shows on the output register in the cycle after the input transaction
// throughput: one transaction per cycle; the output register holds a result while the
//   downstream side stalls and a new transaction is taken in the cycle it is released
// reset (rst_n, synchronous): extended telemetry off, schedule counters zero,
//   divisors back to 40/200/200, output empty
module dshot_telemetry_frame_encoder
  import dtfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] period_time, [16] motor_running, [32:17] motor_current,
  // [48:33] battery_level, [56:49] temperature_deg, [63:57] zero
  input  logic [63:0] in_tdata,
  // [0] edt_start, [1] edt_stop
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [20:0] line_pattern, [36:21] frame_word, [39:37] zero
  output logic [39:0] out_tdata,
  // [0] is_extended
  output logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0] cur_div_r, volt_div_r, temp_div_r;
  logic       edt_en_r, edt_en_nxt;
  logic       last_ext_r, last_ext_nxt;
  logic [7:0] cur_cnt_r, cur_cnt_nxt;
  logic [7:0] volt_cnt_r, volt_cnt_nxt;
  logic [7:0] temp_cnt_r, temp_cnt_nxt;

  logic        out_valid_r;
  logic [20:0] line_r, line_nxt;
  logic [15:0] word_r, word_nxt;
  logic        ext_flag_r, ext_flag_nxt;

  logic        start_req, stop_req, accept;
  logic [11:0] ext_payload, payload;
  logic [15:0] period_eff;
  logic [2:0]  shift_amt;
  logic [7:0]  cur_inc, volt_inc, temp_inc;
  logic [27:0] amps_prod;
  logic [7:0]  amps_byte;
  logic [32:0] batt_prod;
  logic [7:0]  batt_byte;
  logic [3:0]  csum;
  logic [19:0] gcr;
  logic [15:0] f_period, f_current, f_battery;
  logic        f_running;
  logic [7:0]  f_temp;
  logic [15:0] mant_full;

  assign start_req = in_tuser[0];
  assign stop_req  = in_tuser[1];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // input fields from their tdata slices
  assign f_period  = in_tdata[15:0];
  assign f_running = in_tdata[16];
  assign f_current = in_tdata[32:17];
  assign f_battery = in_tdata[48:33];
  assign f_temp    = in_tdata[56:49];

  // current byte: nonpositive sends 0, else /100 saturated at 255
  assign amps_prod = {13'd0, f_current[14:0]} * {15'd0, Recip100};
  always_comb begin
    if (f_current == 16'd0 || f_current[15]) begin
      amps_byte = 8'd0;
    end else if (f_current[14:0] >= AmpsSatLimit) begin
      amps_byte = 8'hFF;
    end else begin
      amps_byte = amps_prod[Recip100Shift +: 8];
    end
  end

  assign batt_prod = {17'd0, f_battery} * {16'd0, Recip25};
  assign batt_byte = batt_prod[Recip25Shift +: 8];

  assign cur_inc  = (cur_cnt_r == 8'hFF) ? cur_cnt_r : cur_cnt_r + 8'd1;
  assign volt_inc = (volt_cnt_r == 8'hFF) ? volt_cnt_r : volt_cnt_r + 8'd1;
  assign temp_inc = (temp_cnt_r == 8'hFF) ? temp_cnt_r : temp_cnt_r + 8'd1;

  // frame scheduling
  always_comb begin
    ext_payload  = 12'd0;
    edt_en_nxt   = edt_en_r;
    last_ext_nxt = last_ext_r;
    cur_cnt_nxt  = cur_cnt_r;
    volt_cnt_nxt = volt_cnt_r;
    temp_cnt_nxt = temp_cnt_r;
    if (start_req) begin
      ext_payload = ExtStartFrame;
      edt_en_nxt  = 1'b1;
    end else if (stop_req) begin
      ext_payload = ExtStopFrame;
      edt_en_nxt  = 1'b0;
    end else if (edt_en_r) begin
      if (last_ext_r) begin
        last_ext_nxt = 1'b0;
      end else begin
        cur_cnt_nxt  = cur_inc;
        volt_cnt_nxt = volt_inc;
        temp_cnt_nxt = temp_inc;
        if (cur_inc >= cur_div_r) begin
          ext_payload = {ExtCurrent, amps_byte};
          cur_cnt_nxt = 8'd0;
        end else if (volt_inc >= volt_div_r) begin
          ext_payload  = {ExtVoltage, batt_byte};
          volt_cnt_nxt = 8'd0;
        end else if (temp_inc >= temp_div_r) begin
          ext_payload  = {ExtTemp, f_temp};
          temp_cnt_nxt = 8'd0;
        end
      end
    end
    if (ext_payload != 12'd0) begin
      last_ext_nxt = 1'b1;
    end
  end

  // erpm: exponent from the leading one, nine-bit mantissa
  assign period_eff = f_running ? f_period : StoppedPeriod;
  always_comb begin
    case (period_eff[15:9]) inside
      7'b1??????: shift_amt = 3'd7;
      7'b01?????: shift_amt = 3'd6;
      7'b001????: shift_amt = 3'd5;
      7'b0001???: shift_amt = 3'd4;
      7'b00001??: shift_amt = 3'd3;
      7'b000001?: shift_amt = 3'd2;
      7'b0000001: shift_amt = 3'd1;
      default:    shift_amt = 3'd0;
    endcase
  end

  assign mant_full = period_eff >> shift_amt;
  assign payload   = (ext_payload != 12'd0) ? ext_payload : {shift_amt, mant_full[8:0]};

  assign csum     = ~(payload[3:0] ^ payload[7:4] ^ payload[11:8]);
  assign word_nxt = {payload, csum};
  assign gcr      = {gcr_encode(word_nxt[15:12]), gcr_encode(word_nxt[11:8]),
                     gcr_encode(word_nxt[7:4]), gcr_encode(word_nxt[3:0])};

  // each line bit is the inverted running parity of the gcr bits from the top down; bit 20 is one
  always_comb begin
    line_nxt[20] = 1'b1;
    for (int i = 0; i < 20; i++) begin
      line_nxt[i] = ~(^(gcr >> i));
    end
  end

  assign ext_flag_nxt = (ext_payload != 12'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_div_r  <= CurrentDivReset;
      volt_div_r <= VoltageDivReset;
      temp_div_r <= TempDivReset;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CURRENT_DIV: cur_div_r  <= cfg_wdata;
        CFG_VOLTAGE_DIV: volt_div_r <= cfg_wdata;
        CFG_TEMP_DIV:    temp_div_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edt_en_r    <= 1'b0;
      last_ext_r  <= 1'b0;
      cur_cnt_r   <= 8'd0;
      volt_cnt_r  <= 8'd0;
      temp_cnt_r  <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        edt_en_r    <= edt_en_nxt;
        last_ext_r  <= last_ext_nxt;
        cur_cnt_r   <= cur_cnt_nxt;
        volt_cnt_r  <= volt_cnt_nxt;
        temp_cnt_r  <= temp_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_r     <= line_nxt;
      word_r     <= word_nxt;
      ext_flag_r <= ext_flag_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, word_r, line_r};
  assign out_tuser  = ext_flag_r;

endmodule
